// ===== rtl/owm_pkg.sv =====
// Package for the 1-Wire bus master: phase and command codes, register
// indexes and register reset values. No dependencies.
package owm_pkg;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_RST_LOW   = 3'd1,
        PH_RST_WAIT  = 3'd2,
        PH_RST_TAIL  = 3'd3,
        PH_SLOT_LOW  = 3'd4,
        PH_SLOT_WAIT = 3'd5,
        PH_SLOT_TAIL = 3'd6,
        PH_SLOT_REC  = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        CMD_RESET      = 3'd0,
        CMD_WRITE_BYTE = 3'd1,
        CMD_READ_BYTE  = 3'd2,
        CMD_WRITE_BIT  = 3'd3,
        CMD_READ_BIT   = 3'd4
    } cmd_t;

    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WRITE0_LOW    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WRITE1_LOW    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SAMPLE_WAIT   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SLOT_TAIL     = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_RECOVERY      = 3'd7;

    typedef logic [15:0] ticks_t;

    localparam ticks_t REG_RESET_VAL [NUM_REGS] = '{
        16'd2000, 16'd400, 16'd1600, 16'd400, 16'd40, 16'd40, 16'd240, 16'd40
    };

    localparam ticks_t READ_LOW_TICKS = 16'd4;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

// ===== rtl/one_wire_bus_master_unit.sv =====
// Each accepted input beat yields a registered result beat in the next cycle.
// Throughput: one input beat per cycle; the next beat is taken while a result
// waits, as long as the output register is free or drained in the same cycle.
// Each tick beat while busy advances the phase counter by one via a single compare.
// Reset (aresetn, synchronous, active low) sets the timing registers to their
// defaults, the bus master to idle with presence level 1, and drops m_valid.
module one_wire_bus_master_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic [2:0]                    s_command,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_line_level,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_drive_low,
    output logic                          m_busy_res,
    output logic                          m_done_res,
    output logic [7:0]                    m_read_data,
    output logic                          m_presence_level,
    output logic                          m_rejected,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [owm_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);
    import owm_pkg::*;

    ticks_t     cfg_reg [NUM_REGS];
    phase_t     phase_reg, phase_next;
    ticks_t     cnt_reg, cnt_next;
    logic [7:0] shift_reg, shift_next;
    logic [3:0] bits_reg, bits_next;
    logic [2:0] op_reg, op_next;
    logic       pres_reg, pres_next;

    logic       m_valid_reg;
    logic       drive_reg, busy_reg, done_reg, rej_reg;
    logic [7:0] rd_reg;

    logic       s_fire;
    logic       op_read;
    ticks_t     dur_raw, dur, cnt_inc;
    logic       done_next, rej_next;
    logic [7:0] rd_next;
    logic [3:0] bits_dec;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= REG_RESET_VAL[i];
            end
        end else if (cfg_valid) begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    assign op_read = (op_reg == CMD_READ_BYTE) || (op_reg == CMD_READ_BIT);

    always_comb begin
        unique case (phase_reg)
            PH_RST_LOW:   dur_raw = cfg_reg[REG_RESET_LOW];
            PH_RST_WAIT:  dur_raw = cfg_reg[REG_PRESENCE_WAIT];
            PH_RST_TAIL:  dur_raw = cfg_reg[REG_RESET_TAIL];
            PH_SLOT_LOW:  dur_raw = op_read ? READ_LOW_TICKS :
                                    (shift_reg[0] ? cfg_reg[REG_WRITE1_LOW]
                                                  : cfg_reg[REG_WRITE0_LOW]);
            PH_SLOT_WAIT: dur_raw = cfg_reg[REG_SAMPLE_WAIT];
            PH_SLOT_TAIL: dur_raw = cfg_reg[REG_SLOT_TAIL];
            PH_SLOT_REC:  dur_raw = cfg_reg[REG_RECOVERY];
            default:      dur_raw = 16'd1;
        endcase
        // A programmed duration of zero behaves as one tick.
        dur     = (dur_raw == 16'd0) ? 16'd1 : dur_raw;
        cnt_inc = (cnt_reg == 16'hFFFF) ? cnt_reg : cnt_reg + 16'd1;
    end

    assign bits_dec = (bits_reg != 4'd0) ? bits_reg - 4'd1 : bits_reg;

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        op_next    = op_reg;
        pres_next  = pres_reg;
        done_next  = 1'b0;
        rej_next   = 1'b0;
        rd_next    = 8'd0;

        if (s_kind) begin
            if (phase_reg != PH_IDLE) begin
                rej_next = 1'b1;
            end else begin
                op_next  = s_command;
                cnt_next = 16'd0;
                unique case (s_command)
                    CMD_RESET: begin
                        phase_next = PH_RST_LOW;
                        bits_next  = 4'd0;
                    end
                    CMD_WRITE_BYTE: begin
                        phase_next = PH_SLOT_LOW;
                        shift_next = s_data_byte;
                        bits_next  = BITS_PER_BYTE;
                    end
                    CMD_READ_BYTE: begin
                        phase_next = PH_SLOT_LOW;
                        shift_next = 8'd0;
                        bits_next  = BITS_PER_BYTE;
                    end
                    CMD_WRITE_BIT: begin
                        phase_next = PH_SLOT_LOW;
                        shift_next = {7'd0, s_data_byte[0]};
                        bits_next  = 4'd1;
                    end
                    CMD_READ_BIT: begin
                        phase_next = PH_SLOT_LOW;
                        shift_next = 8'd0;
                        bits_next  = 4'd1;
                    end
                    default: begin
                        // Unknown command codes leave the state untouched.
                        op_next  = op_reg;
                        cnt_next = cnt_reg;
                        rej_next = 1'b1;
                    end
                endcase
            end
        end else if (phase_reg != PH_IDLE) begin
            cnt_next = cnt_inc;
            if (cnt_inc >= dur) begin
                cnt_next = 16'd0;
                unique case (phase_reg)
                    PH_RST_LOW:  phase_next = PH_RST_WAIT;
                    PH_RST_WAIT: begin
                        pres_next  = s_line_level;
                        phase_next = PH_RST_TAIL;
                    end
                    PH_RST_TAIL: begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                    PH_SLOT_LOW: begin
                        if (op_read) begin
                            phase_next = PH_SLOT_WAIT;
                        end else begin
                            phase_next = shift_reg[0] ? PH_SLOT_TAIL : PH_SLOT_REC;
                        end
                    end
                    PH_SLOT_WAIT: begin
                        if (op_reg == CMD_READ_BYTE) begin
                            shift_next = {s_line_level, shift_reg[7:1]};
                        end else begin
                            shift_next = {7'd0, s_line_level};
                        end
                        phase_next = PH_SLOT_TAIL;
                    end
                    PH_SLOT_TAIL: phase_next = PH_SLOT_REC;
                    PH_SLOT_REC: begin
                        bits_next = bits_dec;
                        if (!op_read) begin
                            shift_next = {1'b0, shift_reg[7:1]};
                        end
                        if (bits_dec != 4'd0) begin
                            phase_next = PH_SLOT_LOW;
                        end else begin
                            phase_next = PH_IDLE;
                            done_next  = 1'b1;
                            // Read data shows the assembled value on completion.
                            if (op_read) begin
                                rd_next = shift_reg;
                            end
                        end
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= 16'd0;
            shift_reg <= 8'd0;
            bits_reg  <= 4'd0;
            op_reg    <= 3'd0;
            pres_reg  <= 1'b1;
        end else if (s_fire) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            op_reg    <= op_next;
            pres_reg  <= pres_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            drive_reg <= (phase_next == PH_RST_LOW) || (phase_next == PH_SLOT_LOW);
            busy_reg  <= (phase_next != PH_IDLE);
            done_reg  <= done_next;
            rd_reg    <= rd_next;
            rej_reg   <= rej_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_drive_low      = drive_reg;
    assign m_busy_res       = busy_reg;
    assign m_done_res       = done_reg;
    assign m_read_data      = rd_reg;
    assign m_presence_level = pres_reg;
    assign m_rejected       = rej_reg;

endmodule

// ===== rtl/owm_checker.sv =====
// Port-level checks for one_wire_bus_master_unit, attached with a bind.
// Depends on the top level's port list only.
module owm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_drive_low,
    input logic       m_busy_res,
    input logic       m_done_res,
    input logic [7:0] m_read_data,
    input logic       m_presence_level,
    input logic       m_rejected
);

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_low) && $stable(m_busy_res)
            && $stable(m_done_res) && $stable(m_read_data) && $stable(m_presence_level)
            && $stable(m_rejected))
        else $error("result beat changed while stalled");

    // Completion always leaves the master idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> !m_busy_res)
        else $error("done while still busy");

    // A rejected command cannot also complete an operation.
    a_rej_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> !m_done_res)
        else $error("rejected beat reports done");

    // The line is only pulled low during an operation.
    a_drive_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_drive_low |-> m_busy_res)
        else $error("line driven while idle");

    // Read data is zero except on a completing beat.
    a_rd_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_read_data != 8'd0) |-> m_done_res)
        else $error("read data outside completion");

endmodule

bind one_wire_bus_master_unit owm_checker u_owm_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_drive_low      (m_drive_low),
    .m_busy_res       (m_busy_res),
    .m_done_res       (m_done_res),
    .m_read_data      (m_read_data),
    .m_presence_level (m_presence_level),
    .m_rejected       (m_rejected)
);
